FILE: rtl/hrrn_tick_scheduler_assert.svh
// ----------------------------------------------------------------------------
// hrrn tick scheduler assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HRRN_TICK_SCHEDULER_ASSERT_SVH
`define HRRN_TICK_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define HRRN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrrn scheduler assertion failed");
// next-cycle implication
`define HRRN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrrn scheduler assertion failed");
`else
`define HRRN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HRRN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/hrrn_pkg.sv
// ----------------------------------------------------------------------------
// hrrn_pkg
// shared types and constants of the hrrn tick scheduler
// ----------------------------------------------------------------------------
package hrrn_pkg;

   // fixed field widths of the request and response words
   localparam int ID_BITS         = 5;
   localparam int FIELD_TIME_BITS = 16;
   localparam int FRAC_BITS       = 8;
   localparam int NORM_BITS       = 24;

   // request word modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_PICK,
      ST_UPD,
      ST_DIV,
      ST_RSP
   } hrrn_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_wr;
      logic tick_start;
      logic mul;
      logic cmp;
      logic pick_rd;
      logic upd;
      logic rsp_load;
   } hrrn_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic run_done;
      logic div_done;
      logic rsp_free;
   } hrrn_stat_type;

endpackage

FILE: rtl/hrrn_tick_scheduler.sv
// ----------------------------------------------------------------------------
// hrrn_tick_scheduler
// highest response ratio next scheduler, one time unit per tick word
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, process_id, arrival, burst
//   rsp      out        rsp_valid/stall    tick time, slot, completion figures
//
// a load word is written to its slot while the block is idle; a tick word
// runs the slot scan (multiply, then compare, for each slot), then the pick
// and the update of the run slot, and the one-bit-a-cycle divider when that
// slot completes. synchronous reset clears the time counter and the pending
// flag of every slot. the response register holds a finished word while
// rsp_stall is high; the next tick waits at the hand-off until the register is free.
// ----------------------------------------------------------------------------
module hrrn_tick_scheduler
   import hrrn_pkg::*;
#(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [ID_BITS-1:0]         req_process_id,
   input  logic [FIELD_TIME_BITS-1:0] req_arrival_time,
   input  logic [FIELD_TIME_BITS-1:0] req_burst_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [FIELD_TIME_BITS-1:0] rsp_tick_time,
   output logic                       rsp_idle,
   output logic [ID_BITS-1:0]         rsp_running_id,
   output logic                       rsp_finished,
   output logic [FIELD_TIME_BITS-1:0] rsp_finish_time,
   output logic [FIELD_TIME_BITS-1:0] rsp_turnaround,
   output logic [NORM_BITS-1:0]       rsp_norm_turnaround,
   output logic                       rsp_all_done
);

   hrrn_cmd_type  cmd;
   hrrn_stat_type stat;

   // sequencer
   hrrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot store, scan and response datapath
   hrrn_dp #(
      .MAX_PROCS (MAX_PROCS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_process_id      (req_process_id),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_tick_time       (rsp_tick_time),
      .rsp_idle            (rsp_idle),
      .rsp_running_id      (rsp_running_id),
      .rsp_finished        (rsp_finished),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_norm_turnaround (rsp_norm_turnaround),
      .rsp_all_done        (rsp_all_done)
   );

endmodule

FILE: rtl/hrrn_div.sv
// ----------------------------------------------------------------------------
// hrrn_div
// restoring divider, one quotient bit a cycle, for (turnaround << 8) / burst
// with the quotient saturated to the response field width
// ----------------------------------------------------------------------------
module hrrn_div
   import hrrn_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] numer,
   input  logic [TIME_BITS-1:0] denom,
   output logic                 done,
   output logic [NORM_BITS-1:0] quot_sat
);

   localparam int Q_BITS   = TIME_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(Q_BITS + 1);

   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [Q_BITS-1:0]           dq_ff, dq_in;
   logic [TIME_BITS-1:0]        rem_ff, rem_in;
   logic [TIME_BITS-1:0]        den_ff;
   logic [TIME_BITS:0]          rem_sh;
   logic [TIME_BITS:0]          rem_sub;
   logic [Q_BITS+NORM_BITS-1:0] q_ext;
   logic [Q_BITS+NORM_BITS-1:0] q_max;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, dq_ff[Q_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = CNT_BITS'(Q_BITS);
         dq_in  = {numer, {FRAC_BITS{1'b0}}};
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[TIME_BITS-1:0];
            dq_in  = {dq_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[TIME_BITS-1:0];
            dq_in  = {dq_ff[Q_BITS-2:0], 1'b0};
         end
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // quotient and remainder
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   // saturate to the field width
   always_comb begin
      q_ext = {{NORM_BITS{1'b0}}, dq_ff};
      q_max = {{Q_BITS{1'b0}}, {NORM_BITS{1'b1}}};
      if (q_ext > q_max) begin
         quot_sat = {NORM_BITS{1'b1}};
      end else begin
         quot_sat = q_ext[NORM_BITS-1:0];
      end
   end

   assign done = (cnt_ff == '0);

endmodule

FILE: rtl/hrrn_dp.sv
// ----------------------------------------------------------------------------
// hrrn_dp
// slot store, ratio scan by cross-multiplication, time counter, completion
// figures and the response register
// ----------------------------------------------------------------------------
`include "hrrn_tick_scheduler_assert.svh"

module hrrn_dp
   import hrrn_pkg::*;
#(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hrrn_cmd_type               cmd,
   output hrrn_stat_type              stat,
   input  logic [ID_BITS-1:0]         req_process_id,
   input  logic [FIELD_TIME_BITS-1:0] req_arrival_time,
   input  logic [FIELD_TIME_BITS-1:0] req_burst_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [FIELD_TIME_BITS-1:0] rsp_tick_time,
   output logic                       rsp_idle,
   output logic [ID_BITS-1:0]         rsp_running_id,
   output logic                       rsp_finished,
   output logic [FIELD_TIME_BITS-1:0] rsp_finish_time,
   output logic [FIELD_TIME_BITS-1:0] rsp_turnaround,
   output logic [NORM_BITS-1:0]       rsp_norm_turnaround,
   output logic                       rsp_all_done
);

   localparam int IDX_BITS  = $clog2(MAX_PROCS);
   localparam int PROD_BITS = 2 * TIME_BITS;
   localparam int WID_BITS  = IDX_BITS + ID_BITS;

   // field width conversions
   function automatic logic [TIME_BITS-1:0] from_field(input logic [FIELD_TIME_BITS-1:0] v);
      logic [TIME_BITS+FIELD_TIME_BITS-1:0] wide;
      wide = {{TIME_BITS{1'b0}}, v};
      return wide[TIME_BITS-1:0];
   endfunction

   function automatic logic [FIELD_TIME_BITS-1:0] to_field(input logic [TIME_BITS-1:0] v);
      logic [TIME_BITS+FIELD_TIME_BITS-1:0] wide;
      wide = {{FIELD_TIME_BITS{1'b0}}, v};
      return wide[FIELD_TIME_BITS-1:0];
   endfunction

   // slot store
   logic [TIME_BITS-1:0] slot_arrival_ff   [MAX_PROCS];
   logic [TIME_BITS-1:0] slot_burst_ff     [MAX_PROCS];
   logic [TIME_BITS-1:0] slot_remaining_ff [MAX_PROCS];
   logic [TIME_BITS-1:0] rd_arrival_ff, rd_burst_ff, rd_remaining_ff;
   logic [MAX_PROCS-1:0] pending_ff;

   logic [TIME_BITS-1:0] time_now_ff, start_ff, time_next;
   logic [IDX_BITS-1:0]  idx_ff, idx_next;

   logic                 cand_elig_ff;
   logic [TIME_BITS-1:0] cand_wait_ff, cand_burst_ff;
   logic [PROD_BITS-1:0] prod_a_ff, prod_b_ff;
   logic                 cand_elig;
   logic [TIME_BITS-1:0] cand_wait;

   logic                 best_valid_ff;
   logic [IDX_BITS-1:0]  best_idx_ff;
   logic [TIME_BITS-1:0] best_wait_ff, best_burst_ff;

   logic                 done_ff;
   logic [TIME_BITS-1:0] finish_ff, turn_ff, turn;
   logic                 run_done;

   logic [ID_BITS-1:0]   id_m1;
   logic [WID_BITS-1:0]  id_wide, run_wide;
   logic [IDX_BITS-1:0]  load_slot;
   logic                 id_ok;
   logic [TIME_BITS-1:0] arrival_in, burst_in;

   logic [IDX_BITS-1:0]  wr_addr, rd_addr;
   logic                 rd_en, rem_wr;

   logic                 div_done;
   logic [NORM_BITS-1:0] div_quot;

   logic                       rsp_valid_ff;
   logic [FIELD_TIME_BITS-1:0] rsp_tick_time_ff, rsp_finish_time_ff, rsp_turnaround_ff;
   logic                       rsp_idle_ff, rsp_finished_ff, rsp_all_done_ff;
   logic [ID_BITS-1:0]         rsp_running_id_ff;
   logic [NORM_BITS-1:0]       rsp_norm_ff;

   // load word decode
   always_comb begin
      id_m1      = req_process_id - ID_BITS'(1);
      id_wide    = {{IDX_BITS{1'b0}}, id_m1};
      load_slot  = id_wide[IDX_BITS-1:0];
      id_ok      = (req_process_id != '0) &&
                   ({{IDX_BITS{1'b0}}, req_process_id} <= WID_BITS'(MAX_PROCS));
      arrival_in = from_field(req_arrival_time);
      burst_in   = from_field(req_burst_time);
   end

   // store port addressing
   always_comb begin
      idx_next = idx_ff + IDX_BITS'(1);
      wr_addr  = cmd.load_wr ? load_slot : best_idx_ff;
      if (cmd.pick_rd) begin
         rd_addr = best_idx_ff;
      end else if (cmd.tick_start) begin
         rd_addr = '0;
      end else begin
         rd_addr = idx_next;
      end
      rd_en  = cmd.tick_start || cmd.pick_rd || (cmd.cmp && !stat.scan_last);
      rem_wr = cmd.upd && best_valid_ff;
   end

   // slot store, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.load_wr && id_ok) begin
         slot_arrival_ff[wr_addr]   <= arrival_in;
         slot_burst_ff[wr_addr]     <= burst_in;
         slot_remaining_ff[wr_addr] <= burst_in;
      end else if (rem_wr) begin
         slot_remaining_ff[wr_addr] <= rd_remaining_ff - TIME_BITS'(1);
      end
      if (rd_en) begin
         rd_arrival_ff   <= slot_arrival_ff[rd_addr];
         rd_burst_ff     <= slot_burst_ff[rd_addr];
         rd_remaining_ff <= slot_remaining_ff[rd_addr];
      end
   end

   // candidate eligibility and wait
   always_comb begin
      cand_elig = pending_ff[idx_ff] && (rd_arrival_ff <= start_ff);
      cand_wait = start_ff - rd_arrival_ff;
   end

   // cross products, registered before the compare
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         cand_elig_ff  <= cand_elig;
         cand_wait_ff  <= cand_wait;
         cand_burst_ff <= rd_burst_ff;
         prod_a_ff     <= {{TIME_BITS{1'b0}}, cand_wait} * {{TIME_BITS{1'b0}}, best_burst_ff};
         prod_b_ff     <= {{TIME_BITS{1'b0}}, best_wait_ff} * {{TIME_BITS{1'b0}}, rd_burst_ff};
      end
   end

   // best slot so far, strict compare keeps the lowest slot on a tie
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         best_valid_ff <= 1'b0;
         idx_ff        <= '0;
         start_ff      <= time_now_ff;
      end else if (cmd.cmp) begin
         if (cand_elig_ff && (!best_valid_ff || (prod_a_ff > prod_b_ff))) begin
            best_valid_ff <= 1'b1;
            best_idx_ff   <= idx_ff;
            best_wait_ff  <= cand_wait_ff;
            best_burst_ff <= cand_burst_ff;
         end
         if (!stat.scan_last) begin
            idx_ff <= idx_next;
         end
      end
   end

   // time advance and completion figures
   always_comb begin
      time_next = (time_now_ff != '1) ? (time_now_ff + TIME_BITS'(1)) : time_now_ff;
      run_done  = best_valid_ff && (rd_remaining_ff == TIME_BITS'(1));
      turn      = time_next - rd_arrival_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (cmd.upd) begin
            time_now_ff <= time_next;
            if (run_done) begin
               pending_ff[best_idx_ff] <= 1'b0;
            end
         end
         if (cmd.load_wr && id_ok) begin
            pending_ff[load_slot] <= (burst_in != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         done_ff   <= run_done;
         finish_ff <= run_done ? time_next : '0;
         turn_ff   <= run_done ? turn : '0;
      end
   end

   hrrn_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.upd && run_done),
      .numer    (turn),
      .denom    (rd_burst_ff),
      .done     (div_done),
      .quot_sat (div_quot)
   );

   // response register
   assign run_wide = {{ID_BITS{1'b0}}, best_idx_ff} + WID_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_tick_time_ff   <= to_field(start_ff);
         rsp_idle_ff        <= !best_valid_ff;
         rsp_running_id_ff  <= best_valid_ff ? run_wide[ID_BITS-1:0] : '0;
         rsp_finished_ff    <= done_ff;
         rsp_finish_time_ff <= to_field(finish_ff);
         rsp_turnaround_ff  <= to_field(turn_ff);
         rsp_norm_ff        <= done_ff ? div_quot : '0;
         rsp_all_done_ff    <= ~|pending_ff;
      end
   end

   // status to the controller
   always_comb begin
      stat.scan_last = (idx_ff == IDX_BITS'(MAX_PROCS - 1));
      stat.run_done  = run_done;
      stat.div_done  = div_done;
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tick_time       = rsp_tick_time_ff;
   assign rsp_idle            = rsp_idle_ff;
   assign rsp_running_id      = rsp_running_id_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_finish_time     = rsp_finish_time_ff;
   assign rsp_turnaround      = rsp_turnaround_ff;
   assign rsp_norm_turnaround = rsp_norm_ff;
   assign rsp_all_done        = rsp_all_done_ff;

   // a completing slot leaves the pending set
   `HRRN_ASSERT_NEXT(a_finish_clears_pending, clock, reset, cmd.upd && run_done, !pending_ff[best_idx_ff])
   // a completed run always names a slot
   `HRRN_ASSERT_IMPL(a_finished_not_idle, clock, reset, rsp_valid_ff && rsp_finished_ff, !rsp_idle_ff && (rsp_running_id_ff != '0 || IDX_BITS >= ID_BITS))

endmodule

FILE: rtl/hrrn_ctrl.sv
// ----------------------------------------------------------------------------
// hrrn_ctrl
// sequencer: load, slot scan, pick update, divide and response hand-off
// ----------------------------------------------------------------------------
`include "hrrn_tick_scheduler_assert.svh"

module hrrn_ctrl
   import hrrn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_mode,
   input  hrrn_stat_type stat,
   output hrrn_cmd_type  cmd
);

   hrrn_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_valid && !req_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_TICK)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_CMP;
         ST_CMP: begin
            state_in = stat.scan_last ? ST_PICK : ST_MUL;
         end
         ST_PICK: state_in = ST_UPD;
         ST_UPD: begin
            state_in = stat.run_done ? ST_DIV : ST_RSP;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_wr    = req_valid && (req_mode == MODE_LOAD);
            cmd.tick_start = req_valid && (req_mode == MODE_TICK);
         end
         ST_MUL:  cmd.mul      = 1'b1;
         ST_CMP:  cmd.cmp      = 1'b1;
         ST_PICK: cmd.pick_rd  = 1'b1;
         ST_UPD:  cmd.upd      = 1'b1;
         ST_DIV:  cmd          = '0;
         ST_RSP:  cmd.rsp_load = stat.rsp_free;
         default: cmd          = '0;
      endcase
   end

   // an accepted tick word starts the scan
   `HRRN_ASSERT_NEXT(a_tick_starts_scan, clock, reset, (state_ff == ST_IDLE) && req_valid && (req_mode == MODE_TICK), state_ff == ST_MUL)
   // no divide unless the picked slot completes
   `HRRN_ASSERT_NEXT(a_div_only_on_finish, clock, reset, (state_ff == ST_UPD) && !stat.run_done, state_ff == ST_RSP)

endmodule

FILE: dv/hrrn_tick_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrrn_tick_scheduler_tb
// self-checking bench for the highest response ratio next tick scheduler.
// a queue of load and tick words feeds a clocked driver; every accepted word
// updates a local copy of the slot table and time counter, and each tick
// queues the report it should give. a clocked monitor compares every report
// field by field. directed words cover bad slot numbers, reloads, zero burst
// and ties; random episodes load slots and tick, most until they complete.
// ----------------------------------------------------------------------------
module hrrn_tick_scheduler_tb;
   import hrrn_pkg::*;

   localparam int NUM_SLOTS    = 16;
   localparam int TOTAL_WORDS  = 1650;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [NORM_BITS-1:0] NORM_TOP = '1;

   typedef struct packed {
      logic                       mode;
      logic [ID_BITS-1:0]         id;
      logic [FIELD_TIME_BITS-1:0] arrival;
      logic [FIELD_TIME_BITS-1:0] burst;
   } sched_word_t;

   typedef struct packed {
      logic [FIELD_TIME_BITS-1:0] tick_time;
      logic                       idle;
      logic [ID_BITS-1:0]         running_id;
      logic                       finished;
      logic [FIELD_TIME_BITS-1:0] finish_time;
      logic [FIELD_TIME_BITS-1:0] turnaround;
      logic [NORM_BITS-1:0]       norm;
      logic                       all_done;
   } tick_report_t;

   // block ports
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = MODE_LOAD;
   logic [ID_BITS-1:0]         req_process_id = '0;
   logic [FIELD_TIME_BITS-1:0] req_arrival_time = '0;
   logic [FIELD_TIME_BITS-1:0] req_burst_time = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [FIELD_TIME_BITS-1:0] rsp_tick_time;
   logic                       rsp_idle;
   logic [ID_BITS-1:0]         rsp_running_id;
   logic                       rsp_finished;
   logic [FIELD_TIME_BITS-1:0] rsp_finish_time;
   logic [FIELD_TIME_BITS-1:0] rsp_turnaround;
   logic [NORM_BITS-1:0]       rsp_norm_turnaround;
   logic                       rsp_all_done;

   // local copy of the slot table
   logic [FIELD_TIME_BITS-1:0] proc_arrival [NUM_SLOTS];
   logic [FIELD_TIME_BITS-1:0] proc_burst [NUM_SLOTS];
   logic [FIELD_TIME_BITS-1:0] proc_left [NUM_SLOTS];
   logic                       proc_loaded [NUM_SLOTS];
   logic [FIELD_TIME_BITS-1:0] sched_time;

   sched_word_t  pending_words[$];
   tick_report_t expected_ticks[$];

   int          words_sent = 0;
   int          total_words = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned gen_time = 0;

   hrrn_tick_scheduler #(
      .MAX_PROCS(NUM_SLOTS),
      .TIME_BITS(FIELD_TIME_BITS)
   ) DUT (.*);

   always #6 clock = ~clock;

   // idle percentage of either side, by how far the word stream has got
   function automatic int idle_percent(input bit receiver);
      int phase;
      phase = (total_words == 0) ? 0 : (words_sent * 3) / total_words;
      case (phase)
         0: return receiver ? 75 : 16;
         1: return receiver ? 16 : 75;
         default: return 0;
      endcase
   endfunction

   // applies one accepted word to the slot table, queues the tick report
   task automatic run_scheduler_word(input sched_word_t w);
      int                         best;
      logic [63:0]                best_wait;
      logic [63:0]                best_burst;
      logic [63:0]                wait_i;
      logic [FIELD_TIME_BITS-1:0] start;
      logic [31:0]                norm_full;
      tick_report_t               r;
      if (w.mode == MODE_LOAD) begin
         // slot numbers outside 1..NUM_SLOTS are dropped
         if (w.id >= 1 && w.id <= NUM_SLOTS) begin
            proc_arrival[w.id-1] = w.arrival;
            proc_burst[w.id-1]   = w.burst;
            proc_left[w.id-1]    = w.burst;
            proc_loaded[w.id-1]  = 1'b1;
         end
      end else begin
         start      = sched_time;
         best       = -1;
         best_wait  = 0;
         best_burst = 1;
         // exact ratio compare, lowest slot wins a tie
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (proc_loaded[i] && proc_left[i] != 0 && proc_arrival[i] <= start) begin
               wait_i = start - proc_arrival[i];
               if (best < 0 || wait_i * best_burst > best_wait * proc_burst[i]) begin
                  best       = i;
                  best_wait  = wait_i;
                  best_burst = proc_burst[i];
               end
            end
         end
         // time counter saturates
         if (sched_time != '1)
            sched_time = sched_time + 1'b1;
         r = '0;
         r.tick_time = start;
         r.idle      = (best < 0);
         if (best >= 0) begin
            r.running_id    = best + 1;
            proc_left[best] = proc_left[best] - 1'b1;
            if (proc_left[best] == 0) begin
               r.finished    = 1'b1;
               r.finish_time = sched_time;
               r.turnaround  = sched_time - proc_arrival[best];
               if (proc_burst[best] == 0)
                  norm_full = NORM_TOP;
               else
                  norm_full = (32'(r.turnaround) << FRAC_BITS) / proc_burst[best];
               if (norm_full > NORM_TOP)
                  norm_full = NORM_TOP;
               r.norm = norm_full[NORM_BITS-1:0];
            end
         end
         r.all_done = 1'b1;
         for (int i = 0; i < NUM_SLOTS; i++)
            if (proc_loaded[i] && proc_left[i] != 0)
               r.all_done = 1'b0;
         expected_ticks.push_back(r);
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   task automatic queue_load(input int id, input int arrival, input int burst);
      sched_word_t w;
      w.mode    = MODE_LOAD;
      w.id      = id;
      w.arrival = arrival;
      w.burst   = burst;
      pending_words.push_back(w);
   endtask

   task automatic queue_tick();
      sched_word_t w;
      w.mode    = MODE_TICK;
      w.id      = $urandom_range(0, 31);
      w.arrival = $urandom_range(0, 65535);
      w.burst   = $urandom_range(0, 65535);
      pending_words.push_back(w);
      gen_time++;
   endtask

   // driver: offers the head of the word queue, holds it while stalled
   always @(posedge clock) begin : drive_words
      sched_word_t next_word;
      bit          accepted;
      bit          offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            run_scheduler_word(pending_words.pop_front());
            words_sent <= words_sent + 1;
         end
         if (!req_valid || accepted) begin
            offer = (pending_words.size() != 0) &&
                    ($urandom_range(0, 99) >= idle_percent(1'b0));
            req_valid <= offer;
            if (offer) begin
               next_word = pending_words[0];
               req_mode         <= next_word.mode;
               req_process_id   <= next_word.id;
               req_arrival_time <= next_word.arrival;
               req_burst_time   <= next_word.burst;
            end
         end
      end
   end

   // receiver pacing, with one long hold-off late in the run
   always @(posedge clock) begin : pace_reports
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && total_words != 0 && words_sent >= (total_words * 5) / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_percent(1'b1));
      end
   end

   // monitor: each accepted report against the oldest expectation
   always @(posedge clock) begin : check_reports
      tick_report_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t ns: unexpected report, expected none, got tick_time %0d",
                     $time, rsp_tick_time);
            fail_count++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("tick_time", want.tick_time, rsp_tick_time);
            check_field("idle", want.idle, rsp_idle);
            check_field("running_id", want.running_id, rsp_running_id);
            check_field("finished", want.finished, rsp_finished);
            check_field("finish_time", want.finish_time, rsp_finish_time);
            check_field("turnaround", want.turnaround, rsp_turnaround);
            check_field("norm_turnaround", want.norm, rsp_norm_turnaround);
            check_field("all_done", want.all_done, rsp_all_done);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hrrn_tick_scheduler_tb failed");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      int          k;
      int          slot;
      int          offset;
      int          max_off;
      int          burst;
      int          arrival;
      int          work;
      int          ticks;
      int          used [NUM_SLOTS];

      for (int i = 0; i < NUM_SLOTS; i++) begin
         proc_arrival[i] = '0;
         proc_burst[i]   = '0;
         proc_left[i]    = '0;
         proc_loaded[i]  = 1'b0;
      end
      sched_time = '0;

      // idle tick with nothing loaded
      queue_tick();
      // bad slot numbers
      queue_load(0, 0, 5);
      queue_load(17, 'hFFFF, 'hFFFF);
      queue_load(31, 'h1234, 3);
      // top slot, a slot that never arrives, a zero burst slot
      queue_load(16, 0, 1);
      queue_load(1, 'hFFFF, 'hFFFF);
      queue_load(2, 0, 0);
      queue_tick();
      // equal ratios go to the lower slot
      queue_load(3, 1, 2);
      queue_load(4, 1, 2);
      repeat (4) queue_tick();
      // reload while still pending
      queue_load(5, 6, 3);
      queue_tick();
      queue_load(5, 0, 1);
      queue_tick();
      // long burst already arrived, then cleared
      queue_load(6, 0, 'hFFFF);
      queue_tick();
      queue_load(6, 'h8000, 0);
      // clear the slot that never arrives, all done again
      queue_load(1, 0, 0);
      queue_tick();

      // random episodes
      while (pending_words.size() < TOTAL_WORDS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6 || kind == 9) begin
            // load a group of slots, then tick until it is done
            k       = (kind == 6) ? NUM_SLOTS : $urandom_range(1, 6);
            max_off = 0;
            work    = 0;
            for (int j = 0; j < k; j++) begin
               if (kind == 6) begin
                  slot   = j + 1;
                  offset = 0;
                  burst  = $urandom_range(1, 3);
               end else begin
                  slot   = $urandom_range(1, NUM_SLOTS);
                  offset = $urandom_range(0, 6);
                  burst  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
               end
               arrival = gen_time + offset;
               if (kind != 6 && gen_time > 0 && $urandom_range(0, 4) == 0) begin
                  arrival = $urandom_range(0, gen_time);
                  offset  = 0;
               end
               if (offset > max_off)
                  max_off = offset;
               work    += burst;
               used[j]  = slot;
               queue_load(slot, arrival, burst);
            end
            ticks = max_off + work + $urandom_range(0, 2);
            // broken episode: cut short, then cleared with zero bursts
            if (kind == 9)
               ticks = ticks / 2;
            repeat (ticks) queue_tick();
            if (kind == 9)
               for (int j = 0; j < k; j++)
                  queue_load(used[j], $urandom_range(0, 65535), 0);
         end else if (kind == 7) begin
            // loads that the block drops
            repeat ($urandom_range(1, 3)) begin
               slot = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
               queue_load(slot, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            queue_tick();
         end else begin
            // full range slot for a few ticks, then cleared
            slot    = $urandom_range(1, NUM_SLOTS);
            arrival = ($urandom_range(0, 1) == 0) ? $urandom_range(0, gen_time)
                                                  : $urandom_range(0, 65535);
            queue_load(slot, arrival, $urandom_range(1, 65535));
            repeat ($urandom_range(1, 3)) queue_tick();
            queue_load(slot, $urandom_range(0, 65535), 0);
         end
      end
      total_words = pending_words.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_ticks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("hrrn_tick_scheduler_tb passed");
      else
         $display("hrrn_tick_scheduler_tb failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/hrrn_pkg.sv
rtl/hrrn_div.sv
rtl/hrrn_dp.sv
rtl/hrrn_ctrl.sv
rtl/hrrn_tick_scheduler.sv
dv/hrrn_tick_scheduler_tb.sv
